// ----- hdl/bfse_pkg.sv -----
// Shared constants, command codes and the result type of the tape-language step engine.
`timescale 1ns / 1ps

package bfse_pkg;

   // Storage sizes and the address widths that follow from them.
   localparam int TAPE_DEPTH  = 256;
   localparam int TAPE_AW     = $clog2(TAPE_DEPTH);
   localparam int PROG_DEPTH  = 4096;
   localparam int PROG_AW     = $clog2(PROG_DEPTH);
   localparam int STACK_DEPTH = 64;
   localparam int STACK_AW    = $clog2(STACK_DEPTH);
   localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
   localparam int PC_W        = 13;
   localparam int CELL_W      = 8;
   localparam int ERR_W       = 2;
   localparam int KIND_W      = 2;

   // Request kinds.
   localparam logic [KIND_W-1:0] REQ_LOAD    = 2'd0;
   localparam logic [KIND_W-1:0] REQ_STEP    = 2'd1;
   localparam logic [KIND_W-1:0] REQ_RESTART = 2'd2;

   // Command characters.
   localparam logic [7:0] OP_RIGHT = 8'h3E;
   localparam logic [7:0] OP_LEFT  = 8'h3C;
   localparam logic [7:0] OP_INC   = 8'h2B;
   localparam logic [7:0] OP_DEC   = 8'h2D;
   localparam logic [7:0] OP_OUT   = 8'h2E;
   localparam logic [7:0] OP_IN    = 8'h2C;
   localparam logic [7:0] OP_OPEN  = 8'h5B;
   localparam logic [7:0] OP_CLOSE = 8'h5D;

   // Error codes.
   localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
   localparam logic [ERR_W-1:0] ERR_OPEN  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_CLOSE = 2'd2;
   localparam logic [ERR_W-1:0] ERR_NEST  = 2'd3;

   // One result beat, as produced by the execution core.
   typedef struct packed {
      logic              out_valid;
      logic [CELL_W-1:0] out_byte;
      logic              input_used;
      logic              halted;
      logic [ERR_W-1:0]  error_code;
      logic [PC_W-1:0]   program_counter;
   } bfse_result_type;

endpackage

// ----- hdl/bfse_core.sv -----
// Execution core: program, tape and bracket memories under a small sequencer.
`timescale 1ns / 1ps

module bfse_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [bfse_pkg::KIND_W-1:0]     req_kind,
   input  logic [bfse_pkg::PROG_AW-1:0]    prog_addr,
   input  logic [7:0]                      prog_byte,
   input  logic [bfse_pkg::CELL_W-1:0]     in_byte,
   input  logic [bfse_pkg::PC_W-1:0]       prog_len,
   output logic                            idle,
   output logic                            done,
   output bfse_pkg::bfse_result_type       result
);

   localparam logic [1:0] S_IDLE     = 2'd0;
   localparam logic [1:0] S_EXEC     = 2'd1;
   localparam logic [1:0] S_SCAN_RD  = 2'd2;
   localparam logic [1:0] S_SCAN_CHK = 2'd3;

   // Memories.
   logic [7:0]                     prog_mem  [bfse_pkg::PROG_DEPTH];
   logic [bfse_pkg::CELL_W-1:0]    tape_mem  [bfse_pkg::TAPE_DEPTH];
   logic [bfse_pkg::PROG_AW-1:0]   stack_mem [bfse_pkg::STACK_DEPTH];
   logic [7:0]                     prog_rd_ff;
   logic [bfse_pkg::CELL_W-1:0]    tape_rd_ff;
   logic [bfse_pkg::PROG_AW-1:0]   stack_rd_ff;
   logic [bfse_pkg::TAPE_DEPTH-1:0] tape_vld_ff;

   // Sequencer state.
   logic [1:0]                     state_ff, state_in;
   logic [bfse_pkg::PC_W-1:0]      pc_ff, pc_in;
   logic [bfse_pkg::TAPE_AW-1:0]   cp_ff, cp_in;
   logic [bfse_pkg::DEPTH_W-1:0]   depth_ff, depth_in;
   logic                           halt_ff, halt_in;
   logic [bfse_pkg::ERR_W-1:0]     err_ff, err_in;
   logic [bfse_pkg::PC_W-1:0]      scan_ff, scan_in;
   logic [bfse_pkg::PROG_AW-1:0]   level_ff, level_in;
   logic [bfse_pkg::CELL_W-1:0]    in_byte_ff;

   // Memory controls.
   logic                           prog_we;
   logic [bfse_pkg::PROG_AW-1:0]   prog_ra;
   logic                           tape_we;
   logic [bfse_pkg::CELL_W-1:0]    tape_wd;
   logic                           tape_clr;
   logic                           stack_we;
   logic [bfse_pkg::CELL_W-1:0]    cur_cell;
   logic                           emit, took;

   assign cur_cell = tape_vld_ff[cp_ff] ? tape_rd_ff : '0;
   assign idle = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      cp_in    = cp_ff;
      depth_in = depth_ff;
      halt_in  = halt_ff;
      err_in   = err_ff;
      scan_in  = scan_ff;
      level_in = level_ff;
      prog_we  = 1'b0;
      prog_ra  = pc_ff[bfse_pkg::PROG_AW-1:0];
      tape_we  = 1'b0;
      tape_wd  = in_byte_ff;
      tape_clr = 1'b0;
      stack_we = 1'b0;
      emit     = 1'b0;
      took     = 1'b0;
      done     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_kind)
                  bfse_pkg::REQ_LOAD: begin
                     prog_we = 1'b1;
                     done    = 1'b1;
                  end
                  bfse_pkg::REQ_STEP: begin
                     if (halt_ff) begin
                        done = 1'b1;
                     end else if (pc_ff >= prog_len) begin
                        halt_in = 1'b1;
                        done    = 1'b1;
                     end else begin
                        state_in = S_EXEC;
                     end
                  end
                  bfse_pkg::REQ_RESTART: begin
                     tape_clr = 1'b1;
                     pc_in    = '0;
                     cp_in    = '0;
                     depth_in = '0;
                     halt_in  = 1'b0;
                     err_in   = bfse_pkg::ERR_NONE;
                     done     = 1'b1;
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            done     = 1'b1;
            pc_in    = pc_ff + bfse_pkg::PC_W'(1);
            case (prog_rd_ff)
               bfse_pkg::OP_RIGHT: cp_in = cp_ff + bfse_pkg::TAPE_AW'(1);
               bfse_pkg::OP_LEFT:  cp_in = cp_ff - bfse_pkg::TAPE_AW'(1);
               bfse_pkg::OP_INC: begin
                  tape_we = 1'b1;
                  tape_wd = cur_cell + bfse_pkg::CELL_W'(1);
               end
               bfse_pkg::OP_DEC: begin
                  tape_we = 1'b1;
                  tape_wd = cur_cell - bfse_pkg::CELL_W'(1);
               end
               bfse_pkg::OP_OUT: emit = 1'b1;
               bfse_pkg::OP_IN: begin
                  tape_we = 1'b1;
                  took    = 1'b1;
               end
               bfse_pkg::OP_OPEN: begin
                  if (cur_cell == '0) begin
                     // Forward skip: walk the program looking for the partner.
                     pc_in    = pc_ff;
                     scan_in  = pc_ff + bfse_pkg::PC_W'(1);
                     level_in = '0;
                     state_in = S_SCAN_RD;
                     done     = 1'b0;
                  end else if (depth_ff >= bfse_pkg::DEPTH_W'(bfse_pkg::STACK_DEPTH)) begin
                     pc_in  = pc_ff;
                     err_in = bfse_pkg::ERR_NEST;
                  end else begin
                     stack_we = 1'b1;
                     depth_in = depth_ff + bfse_pkg::DEPTH_W'(1);
                  end
               end
               bfse_pkg::OP_CLOSE: begin
                  if (depth_ff == '0) begin
                     pc_in  = pc_ff;
                     err_in = bfse_pkg::ERR_CLOSE;
                  end else if (cur_cell != '0) begin
                     pc_in = {1'b0, stack_rd_ff} + bfse_pkg::PC_W'(1);
                  end else begin
                     depth_in = depth_ff - bfse_pkg::DEPTH_W'(1);
                  end
               end
               default: ;
            endcase
            if (done && (err_in != err_ff || pc_in >= prog_len)) begin
               halt_in = 1'b1;
            end
         end
         S_SCAN_RD: begin
            if (scan_ff >= prog_len) begin
               err_in   = bfse_pkg::ERR_OPEN;
               halt_in  = 1'b1;
               done     = 1'b1;
               state_in = S_IDLE;
            end else begin
               prog_ra  = scan_ff[bfse_pkg::PROG_AW-1:0];
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            scan_in  = scan_ff + bfse_pkg::PC_W'(1);
            state_in = S_SCAN_RD;
            if (prog_rd_ff == bfse_pkg::OP_OPEN) begin
               level_in = level_ff + bfse_pkg::PROG_AW'(1);
            end else if (prog_rd_ff == bfse_pkg::OP_CLOSE) begin
               if (level_ff == '0) begin
                  pc_in    = scan_ff + bfse_pkg::PC_W'(1);
                  halt_in  = (pc_in >= prog_len);
                  done     = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  level_in = level_ff - bfse_pkg::PROG_AW'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      result.out_valid       = emit;
      result.out_byte        = emit ? cur_cell : '0;
      result.input_used      = took;
      result.halted          = halt_in;
      result.error_code      = err_in;
      result.program_counter = pc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pc_ff    <= '0;
         cp_ff    <= '0;
         depth_ff <= '0;
         halt_ff  <= 1'b0;
         err_ff   <= bfse_pkg::ERR_NONE;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         cp_ff    <= cp_in;
         depth_ff <= depth_in;
         halt_ff  <= halt_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || tape_clr) begin
         tape_vld_ff <= '0;
      end else if (tape_we) begin
         tape_vld_ff[cp_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff  <= scan_in;
      level_ff <= level_in;
      if (start) begin
         in_byte_ff <= in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (prog_we) begin
         prog_mem[prog_addr] <= prog_byte;
      end
      prog_rd_ff <= prog_mem[prog_ra];
   end

   always_ff @(posedge clock) begin
      if (tape_we) begin
         tape_mem[cp_ff] <= tape_wd;
      end
      tape_rd_ff <= tape_mem[cp_ff];
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[depth_ff[bfse_pkg::STACK_AW-1:0]] <= pc_ff[bfse_pkg::PROG_AW-1:0];
      end
      stack_rd_ff <= stack_mem[depth_ff[bfse_pkg::STACK_AW-1:0] - bfse_pkg::STACK_AW'(1)];
   end

endmodule

// ----- hdl/brainfuck_step_engine_unit.sv -----
// Top level of the tape-language step engine: stream ports, length register, result register.
`timescale 1ns / 1ps

// A load, restart, undefined or halted step has its result beat in the cycle after
// acceptance; an ordinary step passes through the execute state (program and tape reads,
// then write-back), and a forward skip walks the program a byte at a time through the scan
// read and scan check states, ending in scan read if no partner is found. The next request
// is taken the cycle after the result beat leaves, so no request is taken while one is open.
// Reset is synchronous, active high; the tape reads as zero through per-cell valid bits.

module brainfuck_step_engine_unit (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [bfse_pkg::PC_W-1:0]    csr_wdata,   // program_length

   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [31:0]                  req_tdata,   // prog_addr, prog_byte, in_byte, zero pad
   input  logic [bfse_pkg::KIND_W-1:0]  req_tuser,   // req_type

   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [31:0]                  rsp_tdata,   // out_byte, input_used, halted,
                                                     // error_code, program_counter, zero pad
   output logic                         rsp_tuser    // out_valid
);

   // The length register holds the effective length, so values beyond the
   // program store are clamped once, when they are written.
   logic [bfse_pkg::PC_W-1:0]  len_ff, len_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   bfse_pkg::bfse_result_type  rsp_ff;
   bfse_pkg::bfse_result_type  core_result;
   logic                       core_idle;
   logic                       core_done;
   logic                       start;

   assign csr_ready  = 1'b1;
   assign req_tready = core_idle && !rsp_valid_ff;
   assign start      = req_tvalid && req_tready;

   always_comb begin
      len_in = len_ff;
      if (csr_valid) begin
         if (csr_wdata > bfse_pkg::PC_W'(bfse_pkg::PROG_DEPTH)) begin
            len_in = bfse_pkg::PC_W'(bfse_pkg::PROG_DEPTH);
         end else begin
            len_in = csr_wdata;
         end
      end
   end

   // A result beat is held until the far side takes it; the core cannot finish
   // another item meanwhile because no request is accepted.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (core_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   bfse_core u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_kind  (req_tuser),
      .prog_addr (req_tdata[11:0]),
      .prog_byte (req_tdata[19:12]),
      .in_byte   (req_tdata[27:20]),
      .prog_len  (len_ff),
      .idle      (core_idle),
      .done      (core_done),
      .result    (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (core_done) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.out_valid;
   assign rsp_tdata  = {7'd0,
                        rsp_ff.program_counter,
                        rsp_ff.error_code,
                        rsp_ff.halted,
                        rsp_ff.input_used,
                        rsp_ff.out_byte};

endmodule
